>>> src/sine_hermite_interp_q15_core_defines.svh
// Assertion macros for the sine Hermite interpolation core.
`ifndef SINE_HERMITE_INTERP_Q15_CORE_DEFINES_SVH
`define SINE_HERMITE_INTERP_Q15_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define SHI_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("shi assertion failed");
`define SHI_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("shi assertion failed");
`else
`define SHI_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define SHI_ASSERT_ALWAYS(label, clk, rst_n, cond)
`endif
`endif

>>> src/shi_pkg.sv
// Types, widths and the sine ROM for the Hermite sine core.
package shi_pkg;

    localparam int TABLE_ENTRIES = 128;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int QUARTER       = TABLE_ENTRIES / 4;
    localparam int QW_IDX_W      = IDX_W - 1;
    localparam int ANGLE_W       = 15;
    localparam int FRAC_W        = ANGLE_W - IDX_W;
    localparam int SAMPLE_W      = 17;
    localparam int SLOPE_W       = 12;
    localparam int TSQ_W         = 2 * FRAC_W;
    localparam int T_W           = 15;
    localparam int COEF_W        = 20;
    localparam int TERM_W        = 21;
    localparam int SUM_W         = 23;
    localparam int SINE_W        = 17;
    localparam int S_TDATA_W     = 16;
    localparam int M_TDATA_W     = 24;

    // 2*pi/128 in Q15
    localparam logic signed [SLOPE_W-1:0] SLOPE_SCALE = 12'sd1608;

    localparam logic signed [SAMPLE_W-1:0] QUARTER_WAVE [0:QUARTER] = '{
        17'sd0,     17'sd1608,  17'sd3212,  17'sd4808,
        17'sd6393,  17'sd7962,  17'sd9512,  17'sd11039,
        17'sd12540, 17'sd14010, 17'sd15447, 17'sd16846,
        17'sd18205, 17'sd19520, 17'sd20788, 17'sd22006,
        17'sd23170, 17'sd24279, 17'sd25330, 17'sd26320,
        17'sd27246, 17'sd28106, 17'sd28899, 17'sd29622,
        17'sd30274, 17'sd30853, 17'sd31357, 17'sd31786,
        17'sd32138, 17'sd32413, 17'sd32610, 17'sd32729,
        17'sd32768
    };

    // full-wave sine from the quarter-wave table by symmetry
    function automatic logic signed [SAMPLE_W-1:0] rom_read(input logic [IDX_W-1:0] k);
        logic [1:0]                quad;
        logic [IDX_W-3:0]          r;
        logic [QW_IDX_W-1:0]       qi;
        logic signed [SAMPLE_W-1:0] v;
        quad = k[IDX_W-1 -: 2];
        r    = k[IDX_W-3:0];
        if (quad[0])
            qi = QW_IDX_W'(QUARTER) - {1'b0, r};
        else
            qi = {1'b0, r};
        v = QUARTER_WAVE[qi];
        return quad[1] ? -v : v;
    endfunction

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] f0;
        logic signed [SAMPLE_W-1:0] f1;
        logic signed [SAMPLE_W-1:0] d0;
        logic signed [SAMPLE_W-1:0] d1;
        logic [FRAC_W-1:0]          tf;
    } fetch_t;

    typedef struct packed {
        logic signed [COEF_W-1:0]  a;
        logic signed [COEF_W-1:0]  b;
        logic signed [SLOPE_W-1:0] df0;
        logic signed [SAMPLE_W-1:0] f0;
        logic [T_W-1:0]            t1;
        logic [T_W-1:0]            t2;
        logic [T_W-1:0]            t3;
    } poly_t;

endpackage

>>> src/shi_fetch.sv
// Stage 1: split the angle and read samples and slopes from the ROM.
module shi_fetch
    import shi_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [ANGLE_W-1:0] angle,
    output logic               out_valid,
    input  logic               out_ready,
    output fetch_t             out_data
);

    logic               valid_reg;
    fetch_t             data_reg;
    fetch_t             data_next;
    logic [IDX_W-1:0]   idx0;
    logic [IDX_W-1:0]   idx1;
    logic [IDX_W-1:0]   didx0;
    logic [IDX_W-1:0]   didx1;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        idx0  = angle[ANGLE_W-1 -: IDX_W];
        idx1  = idx0 + IDX_W'(1);
        // cosine at i is sine at quarter turn minus i
        didx0 = IDX_W'(QUARTER) - idx0;
        didx1 = IDX_W'(QUARTER - 1) - idx0;
        data_next.f0 = rom_read(idx0);
        data_next.f1 = rom_read(idx1);
        data_next.d0 = rom_read(didx0);
        data_next.d1 = rom_read(didx1);
        data_next.tf = angle[FRAC_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> src/shi_coef.sv
// Stages 2-3: scale slopes, form t powers and the Hermite coefficients.
module shi_coef
    import shi_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  fetch_t in_data,
    output logic   out_valid,
    input  logic   out_ready,
    output poly_t  out_data
);

    localparam int DPROD_W = SAMPLE_W + SLOPE_W;
    localparam int T3P_W   = TSQ_W + FRAC_W;

    // stage 2 registers
    logic                       v2_reg;
    logic signed [SAMPLE_W-1:0] f0_reg;
    logic signed [SAMPLE_W-1:0] f1_reg;
    logic signed [SLOPE_W-1:0]  df0_reg;
    logic signed [SLOPE_W-1:0]  df1_reg;
    logic [TSQ_W-1:0]           tsq_reg;
    logic [FRAC_W-1:0]          tf_reg;
    // stage 3
    logic                       v3_reg;
    poly_t                      poly_reg;
    poly_t                      poly_next;

    logic                       ready2;
    logic                       ready3;
    logic signed [DPROD_W-1:0]  d0_prod;
    logic signed [DPROD_W-1:0]  d1_prod;
    logic [T3P_W-1:0]           t3_prod;
    logic signed [COEF_W-1:0]   f0_x;
    logic signed [COEF_W-1:0]   f1_x;
    logic signed [COEF_W-1:0]   df0_x;
    logic signed [COEF_W-1:0]   df1_x;

    assign ready3   = !v3_reg || out_ready;
    assign ready2   = !v2_reg || ready3;
    assign in_ready = ready2;

    always_comb
    begin
        d0_prod = DPROD_W'(in_data.d0) * DPROD_W'(SLOPE_SCALE);
        d1_prod = DPROD_W'(in_data.d1) * DPROD_W'(SLOPE_SCALE);
    end

    always_comb
    begin
        f0_x    = COEF_W'(f0_reg);
        f1_x    = COEF_W'(f1_reg);
        df0_x   = COEF_W'(df0_reg);
        df1_x   = COEF_W'(df1_reg);
        t3_prod = T3P_W'(tsq_reg) * T3P_W'(tf_reg);
        poly_next.a   = df0_x + ((f0_x - f1_x) <<< 1) + df1_x;
        poly_next.b   = (f1_x - f0_x) * COEF_W'(3) - (df0_x <<< 1) - df1_x;
        poly_next.df0 = df0_reg;
        poly_next.f0  = f0_reg;
        poly_next.t1  = T_W'({tf_reg, 7'b0});
        poly_next.t2  = T_W'(tsq_reg >> 1);
        poly_next.t3  = T_W'(t3_prod >> 9);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ready2)
                v2_reg <= in_valid;
            if (ready3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready2 && in_valid)
        begin
            f0_reg  <= in_data.f0;
            f1_reg  <= in_data.f1;
            df0_reg <= SLOPE_W'(d0_prod >>> 15);
            df1_reg <= SLOPE_W'(d1_prod >>> 15);
            tsq_reg <= TSQ_W'(in_data.tf) * TSQ_W'(in_data.tf);
            tf_reg  <= in_data.tf;
        end
        if (ready3 && v2_reg)
            poly_reg <= poly_next;
    end

    assign out_valid = v3_reg;
    assign out_data  = poly_reg;

endmodule

>>> src/shi_eval.sv
// Stages 4-5: the three Q15 products, then the final sum into the output register.
module shi_eval
    import shi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  poly_t             in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [SINE_W-1:0] sine
);

    localparam int PA_W = COEF_W + T_W + 1;
    localparam int PC_W = SLOPE_W + T_W + 1;

    logic                       v4_reg;
    logic signed [TERM_W-1:0]   pa_reg;
    logic signed [TERM_W-1:0]   pb_reg;
    logic signed [TERM_W-1:0]   pc_reg;
    logic signed [SAMPLE_W-1:0] f0_reg;
    logic                       v5_reg;
    logic [SINE_W-1:0]          sine_reg;

    logic                       ready4;
    logic                       ready5;
    logic signed [PA_W-1:0]     pa_full;
    logic signed [PA_W-1:0]     pb_full;
    logic signed [PC_W-1:0]     pc_full;
    logic signed [SUM_W-1:0]    sum;

    assign ready5   = !v5_reg || out_ready;
    assign ready4   = !v4_reg || ready5;
    assign in_ready = ready4;

    always_comb
    begin
        pa_full = PA_W'(in_data.a) * $signed(PA_W'({1'b0, in_data.t3}));
        pb_full = PA_W'(in_data.b) * $signed(PA_W'({1'b0, in_data.t2}));
        pc_full = PC_W'(in_data.df0) * $signed(PC_W'({1'b0, in_data.t1}));
        sum     = SUM_W'(pa_reg) + SUM_W'(pb_reg) + SUM_W'(pc_reg) + SUM_W'(f0_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (ready4)
                v4_reg <= in_valid;
            if (ready5)
                v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready4 && in_valid)
        begin
            // floor shift of each product
            pa_reg <= TERM_W'(pa_full >>> 15);
            pb_reg <= TERM_W'(pb_full >>> 15);
            pc_reg <= TERM_W'(pc_full >>> 15);
            f0_reg <= in_data.f0;
        end
        if (ready5 && v4_reg)
            sine_reg <= sum[SINE_W-1:0];
    end

    assign out_valid = v5_reg;
    assign sine      = sine_reg;

endmodule

>>> src/sine_hermite_interp_q15_core.sv
// Throughput: one word per cycle while the output is not held back; an accepted
// angle passes five register stages (ROM read, slope scale and t squared,
// coefficients and t cubed, three products, final sum) to its sine word.
// Stages hold under back-pressure and empty stages fill, so no word is lost.
// Reset (rst_n, async, active low) clears all stage valid bits; data is not reset.
// Top level of the cubic Hermite Q15 sine core.
`include "sine_hermite_interp_q15_core_defines.svh"
module sine_hermite_interp_q15_core
    import shi_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // [14:0] angle, [15] zero
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata   // [16:0] sine, [23:17] zero
);

    localparam logic signed [SINE_W-1:0] SINE_LIMIT = 17'sd32800;

    logic              fetch_valid;
    logic              coef_ready;
    fetch_t            fetch_data;
    logic              coef_valid;
    logic              eval_ready;
    poly_t             coef_data;
    logic [SINE_W-1:0] sine;
    logic              out_held;
    logic              sine_in_range;

    shi_fetch u_fetch (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .angle     (s_axis_tdata[ANGLE_W-1:0]),
        .out_valid (fetch_valid),
        .out_ready (coef_ready),
        .out_data  (fetch_data)
    );

    shi_coef u_coef (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fetch_valid),
        .in_ready  (coef_ready),
        .in_data   (fetch_data),
        .out_valid (coef_valid),
        .out_ready (eval_ready),
        .out_data  (coef_data)
    );

    shi_eval u_eval (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (coef_valid),
        .in_ready  (eval_ready),
        .in_data   (coef_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sine      (sine)
    );

    assign m_axis_tdata = {{(M_TDATA_W - SINE_W){1'b0}}, sine};

    assign out_held      = m_axis_tvalid && !m_axis_tready;
    assign sine_in_range = ($signed(sine) <= SINE_LIMIT) && ($signed(sine) >= -SINE_LIMIT);

    // input stalls only when the output word is held back
    `SHI_ASSERT_IMPLIES(a_stall_from_output, clk, rst_n, !s_axis_tready, out_held)
    `SHI_ASSERT_IMPLIES(a_sine_range, clk, rst_n, m_axis_tvalid, sine_in_range)
    `SHI_ASSERT_IMPLIES(a_inner_drain, clk, rst_n, m_axis_tready, coef_ready && eval_ready)

endmodule

>>> tb/tb_sine_hermite_interp_q15_core.sv
// Self-checking stream testbench for the cubic Hermite Q15 sine core.
module tb_sine_hermite_interp_q15_core;
    import shi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  RANDOM_WORDS   = 750;
    localparam int  QUIET_TAIL     = 120;
    localparam int  LONG_HOLD_AT   = 250;
    localparam int  LONG_HOLD_LEN  = 64;
    localparam int  DRAIN_AT       = 420;
    localparam int  STALL_LIMIT    = 1000;
    localparam int  TAIL_CYCLES    = 20;
    localparam longint SLOPE_Q15   = 1608;

    typedef struct {
        logic [ANGLE_W-1:0] angle;
        bit                 drain;   // hold this word until the pipe is empty
    } angle_req_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;  // [14:0] angle, [15] zero
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;       // [16:0] sine, [23:17] zero

    angle_req_t                 pending_angles[$];
    logic signed [SINE_W-1:0]   expected_sines[$];
    int                         words_in = 0;
    int                         quiet_from = 0;
    int                         errors = 0;
    int                         stall_cycles = 0;
    int                         send_gap = 0;
    int                         hold_left = 0;
    bit                         long_hold_done = 0;
    logic                       in_fire = 1'b0;

    sine_hermite_interp_q15_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    // quarter wave of sin, Q15, entry 32 is exactly one
    localparam longint SIN_QUARTER [0:32] = '{
            0,  1608,  3212,  4808,  6393,  7962,  9512, 11039,
        12540, 14010, 15447, 16846, 18205, 19520, 20788, 22006,
        23170, 24279, 25330, 26320, 27246, 28106, 28899, 29622,
        30274, 30853, 31357, 31786, 32138, 32413, 32610, 32729,
        32768
    };

    function automatic longint wave_sample(input int unsigned idx);
        int unsigned k;
        int unsigned quad;
        int unsigned r;
        longint      v;
        k    = idx & 127;
        quad = k >> 5;
        r    = k & 31;
        v    = quad[0] ? SIN_QUARTER[32 - r] : SIN_QUARTER[r];
        return quad[1] ? -v : v;
    endfunction

    // Q15 product, floor on the shift
    function automatic longint q15_mul(input longint a, input longint b);
        longint p;
        p = a * b;
        return p >>> 15;
    endfunction

    function automatic logic signed [SINE_W-1:0] hermite_sine(input logic [ANGLE_W-1:0] angle);
        int unsigned i0;
        int unsigned i1;
        longint      tf;
        longint      t1;
        longint      t2;
        longint      t3;
        longint      f0;
        longint      f1;
        longint      df0;
        longint      df1;
        longint      ca;
        longint      cb;
        longint      acc;
        i0  = 32'(angle[14:8]);
        i1  = (i0 + 1) & 127;
        tf  = 64'(angle[7:0]);
        t2  = (tf * tf) >>> 1;
        t3  = (tf * tf * tf) >>> 9;
        t1  = tf << 7;
        f0  = wave_sample(i0);
        f1  = wave_sample(i1);
        // slopes come from the cosine, i.e. the sine ROM mirrored about a quarter turn
        df1 = q15_mul(wave_sample(160 - i1), SLOPE_Q15);
        df0 = q15_mul(wave_sample(161 - i1), SLOPE_Q15);
        ca  = df0 + 2 * (f0 - f1) + df1;
        cb  = 3 * (f1 - f0) - 2 * df0 - df1;
        acc = q15_mul(ca, t3) + q15_mul(cb, t2) + q15_mul(df0, t1) + f0;
        return acc[SINE_W-1:0];
    endfunction

    // sender: holds a word until taken, random gaps between words
    always @(negedge clk)
    begin : drive_angles
        logic                 next_valid;
        logic [S_TDATA_W-1:0] next_data;
        angle_req_t           req;
        next_valid = s_axis_tvalid;
        next_data  = s_axis_tdata;
        if (in_fire)
            next_valid = 1'b0;
        if (rst_n && !next_valid)
        begin
            if (send_gap > 0)
                send_gap--;
            else if (pending_angles.size() > 0 &&
                     !(pending_angles[0].drain && expected_sines.size() != 0))
            begin
                req        = pending_angles.pop_front();
                next_data  = {1'b0, req.angle};
                next_valid = 1'b1;
                if (words_in < quiet_from && $urandom_range(3) == 0)
                    send_gap = $urandom_range(4, 1);
            end
        end
        s_axis_tvalid <= next_valid;
        s_axis_tdata  <= next_data;
    end

    // receiver: random short holds, one long hold to back the pipe up
    always @(negedge clk)
    begin : drive_ready
        logic next_ready;
        next_ready = 1'b0;
        if (rst_n)
        begin
            next_ready = 1'b1;
            if (!long_hold_done && words_in >= LONG_HOLD_AT)
            begin
                hold_left      = LONG_HOLD_LEN;
                long_hold_done = 1;
            end
            if (hold_left > 0)
            begin
                next_ready = 1'b0;
                hold_left--;
            end
            else if (words_in < quiet_from && $urandom_range(3) == 0)
            begin
                next_ready = 1'b0;
                hold_left  = $urandom_range(3, 0);
            end
        end
        m_axis_tready <= next_ready;
    end

    // monitor, scoreboard and watchdog
    always @(posedge clk)
    begin : watch_streams
        logic signed [SINE_W-1:0] want;
        logic signed [SINE_W-1:0] got;
        if (rst_n)
        begin
            in_fire <= s_axis_tvalid && s_axis_tready;
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[SINE_W-1:0];
                if (expected_sines.size() == 0)
                begin
                    $error("sine: no word expected, got %0d", got);
                    errors++;
                end
                else
                begin
                    want = expected_sines.pop_front();
                    if (got !== want)
                    begin
                        $error("sine: expected %0d, got %0d", want, got);
                        errors++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_sines.push_back(hermite_sine(s_axis_tdata[ANGLE_W-1:0]));
                words_in++;
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        logic [ANGLE_W-1:0] corner_angles [] = '{
            15'h0000, 15'h7fff, 15'h0001, 15'h00ff, 15'h0100, 15'h0080,
            15'h7f00, 15'h7f80, 15'h7ffe, 15'h1fff, 15'h2000, 15'h20ff,
            15'h3fff, 15'h4000, 15'h5fff, 15'h6000, 15'h6080, 15'h5555,
            15'h2aaa, 15'h1f80
        };
        int unsigned        edge_idx [] = '{0, 1, 31, 32, 33, 63, 64, 95, 96, 126, 127};
        int unsigned        edge_frac [] = '{0, 1, 8'h7f, 8'h80, 8'hfe, 8'hff};
        angle_req_t         req;
        logic [6:0]         idx;
        logic [7:0]         frac;

        foreach (corner_angles[n])
        begin
            req.angle = corner_angles[n];
            req.drain = 0;
            pending_angles.push_back(req);
        end
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            idx  = 7'($urandom_range(127));
            frac = 8'($urandom_range(255));
            case ($urandom_range(3))
                1: frac = 8'(edge_frac[$urandom_range(edge_frac.size() - 1)]);
                2: idx  = 7'(edge_idx[$urandom_range(edge_idx.size() - 1)]);
                default: ;
            endcase
            req.angle = {idx, frac};
            req.drain = (n == DRAIN_AT);
            pending_angles.push_back(req);
        end
        quiet_from = pending_angles.size() - QUIET_TAIL;

        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        while (pending_angles.size() != 0 || s_axis_tvalid || expected_sines.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> sine_hermite_interp_q15_core.f
+incdir+src
src/shi_pkg.sv
src/shi_fetch.sv
src/shi_coef.sv
src/shi_eval.sv
src/sine_hermite_interp_q15_core.sv
tb/tb_sine_hermite_interp_q15_core.sv
